// File: src/aewu_pkg.sv
// Shared types and constants for the ADC event word unpacker.
package aewu_pkg;

  // Word type codes, bits 26:24 of a readout word
  localparam logic [2:0] TypeDatum  = 3'd0;
  localparam logic [2:0] TypeHeader = 3'd2;
  localparam logic [2:0] TypeEnd    = 3'd4;

  localparam logic [6:0] GeoInvalid = 7'd99;

  // Status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadHeader = 3'd1;
  localparam logic [2:0] StNotData   = 3'd2;
  localparam logic [2:0] StGeoMiss   = 3'd3;
  localparam logic [2:0] StNoTrailer = 3'd4;
  localparam logic [2:0] StTruncated = 3'd5;

  typedef struct packed {
    logic        data_word_last;
    logic [31:0] data_word;
  } in_beat_t;

  typedef struct packed {
    logic        event_end;
    logic [4:0]  channel;
    logic [13:0] value;
    logic [6:0]  geo;
    logic [7:0]  crate;
    logic [2:0]  status;
  } result_t;

endpackage

// File: src/aewu_in_stage.sv
// Input register stage: holds one readout beat until the decoder consumes it.
module aewu_in_stage
  import aewu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     stall_o,
  input  logic     take_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     load;

  // Free when empty or the held beat leaves this cycle
  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: src/aewu_decode.sv
// Event decoder: header/data/trailer state and result formation for one word.
module aewu_decode
  import aewu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_beat_t beat_i,
  input  logic     fire_i,
  output logic     has_result_o,
  output result_t  result_o
);

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhData    = 2'd1;
  localparam logic [1:0] PhTrailer = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [5:0] left_q, left_d;
  logic [6:0] geo_q, geo_d;
  logic [7:0] crate_q, crate_d;
  logic       err_q, err_d;

  logic [2:0] wtype;
  logic [6:0] wgeo;
  logic       last;
  logic       has;
  logic       ev_end;
  logic [4:0] chan;
  logic [13:0] val;
  logic [2:0] st;

  assign wtype = beat_i.data_word[26:24];
  assign wgeo  = {2'b00, beat_i.data_word[31:27]};
  assign last  = beat_i.data_word_last;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    geo_d   = geo_q;
    crate_d = crate_q;
    err_d   = err_q;
    has     = 1'b0;
    ev_end  = 1'b0;
    chan    = '0;
    val     = '0;
    st      = StOk;
    unique case (phase_q)
      PhHeader: begin
        if (wtype == TypeHeader) begin
          left_d  = beat_i.data_word[13:8];
          geo_d   = wgeo;
          crate_d = beat_i.data_word[23:16];
          err_d   = 1'b0;
          phase_d = (beat_i.data_word[13:8] != 6'd0) ? PhData : PhTrailer;
          if (last) begin
            phase_d = PhHeader;
            left_d  = '0;
            has     = 1'b1;
            ev_end  = 1'b1;
            st      = StTruncated;
          end
        end else begin
          left_d  = '0;
          geo_d   = GeoInvalid;
          crate_d = '0;
          err_d   = 1'b1;
          has     = 1'b1;
          if (last) begin
            phase_d = PhHeader;
            ev_end  = 1'b1;
            st      = StTruncated;
          end else begin
            phase_d = PhTrailer;
            st      = StBadHeader;
          end
        end
      end
      PhData: begin
        has = 1'b1;
        if (wtype != TypeDatum) begin
          st      = StNotData;
          crate_d = '0;
        end else if (wgeo != geo_q) begin
          st      = StGeoMiss;
          crate_d = '0;
        end else begin
          chan = beat_i.data_word[20:16];
          val  = beat_i.data_word[13:0];
        end
        left_d  = left_q - 6'd1;
        phase_d = (left_d != 6'd0) ? PhData : PhTrailer;
        if (last) begin
          phase_d = PhHeader;
          left_d  = '0;
          ev_end  = 1'b1;
          st      = StTruncated;
        end
      end
      default: begin
        // trailer expected; the spare phase code behaves the same
        phase_d = PhHeader;
        left_d  = '0;
        has     = 1'b1;
        ev_end  = 1'b1;
        if (wtype == TypeEnd) begin
          st = err_q ? StBadHeader : StOk;
        end else begin
          st = StNoTrailer;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      left_q  <= '0;
      geo_q   <= '0;
      crate_q <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      geo_q   <= geo_d;
      crate_q <= crate_d;
      err_q   <= err_d;
    end
  end

  assign has_result_o       = has;
  assign result_o.event_end = ev_end;
  assign result_o.channel   = chan;
  assign result_o.value     = val;
  assign result_o.geo       = geo_d;
  assign result_o.crate     = crate_d;
  assign result_o.status    = st;

endmodule

// File: src/aewu_out_stage.sv
// Result register: holds one result beat until the sink takes it.
module aewu_out_stage
  import aewu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// File: src/adc_event_word_unpacker.sv
// Top level of the ADC event word unpacker.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------------
//  in      | valid_i / stall_o | data_word_i, last_in_buffer_i
//  out     | valid_o / stall_i | event_end_o, channel_o, value_o, geo_o,
//          |                   | crate_o, status_o
//
// One word per cycle while the output is not stalled: a taken beat waits in
// the input register, and when it is consumed the decoder updates event state
// and loads the result register on the same edge; the result then leaves when
// the sink does not stall. A good header without the last flag makes no
// result and does not wait on the output side.
// Reset returns to expecting a header with all event state cleared.
// A stall on the output holds the result register and backs up to stall_o.
module adc_event_word_unpacker
  import aewu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] data_word_i,
  input  logic        last_in_buffer_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        event_end_o,
  output logic [4:0]  channel_o,
  output logic [13:0] value_o,
  output logic [6:0]  geo_o,
  output logic [7:0]  crate_o,
  output logic [2:0]  status_o
);

  in_beat_t in_beat, held_beat;
  logic     held_valid;
  logic     fire;
  logic     has_result;
  logic     out_ready;
  result_t  dec_result, out_result;

  assign in_beat.data_word      = data_word_i;
  assign in_beat.data_word_last = last_in_buffer_i;

  // Consume the held beat when its result (if any) has a place to go
  assign fire = held_valid && (out_ready || !has_result);

  aewu_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .beat_i  (in_beat),
    .stall_o (stall_o),
    .take_i  (fire),
    .valid_o (held_valid),
    .beat_o  (held_beat)
  );

  aewu_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (held_beat),
    .fire_i       (fire),
    .has_result_o (has_result),
    .result_o     (dec_result)
  );

  aewu_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && has_result),
    .result_i (dec_result),
    .ready_o  (out_ready),
    .valid_o  (valid_o),
    .stall_i  (stall_i),
    .result_o (out_result)
  );

  assign event_end_o = out_result.event_end;
  assign channel_o   = out_result.channel;
  assign value_o     = out_result.value;
  assign geo_o       = out_result.geo;
  assign crate_o     = out_result.crate;
  assign status_o    = out_result.status;

endmodule

// File: dv/adc_event_word_unpacker_tb.sv
// Self-checking testbench for the ADC event word unpacker.
`timescale 1ns / 100ps

module adc_event_word_unpacker_tb
  import aewu_pkg::*;
();

  localparam int IdleLimit = 500;  // cycles without any beat before giving up
  localparam int DrainCycles = 8;

  typedef enum logic [1:0] {PhHeader, PhData, PhTrailer} phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [31:0] data_word_i;
  logic        last_in_buffer_i;
  logic        valid_o;
  logic        stall_i;
  logic        event_end_o;
  logic [4:0]  channel_o;
  logic [13:0] value_o;
  logic [6:0]  geo_o;
  logic [7:0]  crate_o;
  logic [2:0]  status_o;

  adc_event_word_unpacker u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .data_word_i      (data_word_i),
    .last_in_buffer_i (last_in_buffer_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .event_end_o      (event_end_o),
    .channel_o        (channel_o),
    .value_o          (value_o),
    .geo_o            (geo_o),
    .crate_o          (crate_o),
    .status_o         (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Event decoder shadow state
  phase_e      ev_phase;
  logic [5:0]  words_left;
  logic [6:0]  ev_geo;
  logic [7:0]  ev_crate;
  logic        ev_err;
  result_t     pending_results[$];

  bit flat_out;
  int n_words;
  int n_results;
  int n_event_ends;
  int n_fail;
  int status_seen[8];

  // Works out the result, if any, that one accepted word causes.
  task automatic predict_word(input logic [31:0] w, input logic last);
    logic [2:0] kind;
    logic [6:0] wgeo;
    result_t    r;
    bit         has;
    kind = w[26:24];
    wgeo = {2'b00, w[31:27]};
    r = '0;
    has = 1'b1;
    case (ev_phase)
      PhHeader: begin
        if (kind == TypeHeader) begin
          words_left = w[13:8];
          ev_geo = wgeo;
          ev_crate = w[23:16];
          ev_err = 1'b0;
          ev_phase = (w[13:8] != 0) ? PhData : PhTrailer;
          if (last) begin
            ev_phase = PhHeader;
            words_left = '0;
            r.event_end = 1'b1;
            r.status = StTruncated;
          end else begin
            has = 1'b0;
          end
        end else begin
          words_left = '0;
          ev_geo = GeoInvalid;
          ev_crate = '0;
          ev_err = 1'b1;
          ev_phase = PhTrailer;
          if (last) begin
            ev_phase = PhHeader;
            r.event_end = 1'b1;
            r.status = StTruncated;
          end else begin
            r.status = StBadHeader;
          end
        end
      end
      PhData: begin
        if (kind != TypeDatum) begin
          r.status = StNotData;
          ev_crate = '0;
        end else if (wgeo != ev_geo) begin
          r.status = StGeoMiss;
          ev_crate = '0;
        end else begin
          r.channel = w[20:16];
          r.value = w[13:0];
        end
        words_left = words_left - 6'd1;
        ev_phase = (words_left != 0) ? PhData : PhTrailer;
        // truncation keeps a good datum but overrides the status
        if (last) begin
          ev_phase = PhHeader;
          words_left = '0;
          r.event_end = 1'b1;
          r.status = StTruncated;
        end
      end
      default: begin
        ev_phase = PhHeader;
        words_left = '0;
        r.event_end = 1'b1;
        if (kind == TypeEnd) r.status = ev_err ? StBadHeader : StOk;
        else r.status = StNoTrailer;
      end
    endcase
    if (has) begin
      r.geo = ev_geo;
      r.crate = ev_crate;
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  function automatic logic [31:0] header_word(logic [4:0] geo, logic [7:0] crate,
                                              logic [5:0] cnt);
    logic [31:0] w;
    w = $urandom;
    w[31:27] = geo;
    w[26:24] = TypeHeader;
    w[23:16] = crate;
    w[13:8] = cnt;
    return w;
  endfunction

  function automatic logic [31:0] datum_word(logic [4:0] geo, logic [4:0] chan,
                                             logic [13:0] val);
    logic [31:0] w;
    w = $urandom;
    w[31:27] = geo;
    w[26:24] = TypeDatum;
    w[20:16] = chan;
    w[13:0] = val;
    return w;
  endfunction

  function automatic logic [31:0] end_word(logic [4:0] geo);
    logic [31:0] w;
    w = $urandom;
    w[31:27] = geo;
    w[26:24] = TypeEnd;
    return w;
  endfunction

  // Random word whose type field differs from the given one.
  function automatic logic [31:0] odd_word(logic [2:0] avoid);
    logic [31:0] w;
    w = $urandom;
    while (w[26:24] == avoid) w = $urandom;
    return w;
  endfunction

  // Entered and left at a falling edge; valid stays up after the beat.
  task automatic send_word(input logic [31:0] w, input logic last);
    int gap;
    if (!flat_out && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    data_word_i <= w;
    last_in_buffer_i <= last;
    do @(posedge clk_i); while (stall_o);
    predict_word(w, last);
    n_words++;
    @(negedge clk_i);
  endtask

  // Mostly well-formed event with random content and occasional faults.
  task automatic play_event();
    logic [4:0] geo;
    logic [7:0] crate;
    int         cnt;
    bit         lst;
    bit         broken;
    int         pick;
    geo = 5'($urandom);
    crate = 8'($urandom);
    cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 63) : $urandom_range(0, 6);
    broken = ($urandom_range(0, 9) == 0);
    lst = ($urandom_range(0, 39) == 0);
    send_word(header_word(geo, crate, 6'(cnt)), lst);
    if (lst) return;
    for (int i = 0; i < cnt; i++) begin
      if (broken && $urandom_range(0, 3) == 0) return;
      lst = ($urandom_range(0, 39) == 0);
      pick = $urandom_range(0, 11);
      if (pick == 0)
        send_word(datum_word(geo ^ 5'($urandom_range(1, 31)), 5'($urandom),
                             14'($urandom)), lst);
      else if (pick == 1)
        send_word(odd_word(TypeDatum), lst);
      else
        send_word(datum_word(geo, 5'($urandom), 14'($urandom)), lst);
      if (lst) return;
    end
    if ($urandom_range(0, 9) == 0) send_word(odd_word(TypeEnd), $urandom_range(0, 3) == 0);
    else send_word(end_word(geo), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_good_events();
    send_word(header_word(5'd0, 8'd0, 6'd0), 1'b0);
    send_word(end_word(5'd0), 1'b0);
    send_word(header_word(5'd31, 8'd255, 6'd2), 1'b0);
    send_word(datum_word(5'd31, 5'd31, 14'h3fff), 1'b0);
    send_word(datum_word(5'd31, 5'd0, 14'h0000), 1'b0);
    send_word(end_word(5'd31), 1'b0);
  endtask

  task automatic test_bad_headers();
    send_word(end_word(5'd3), 1'b0);          // stray trailer
    send_word(end_word(5'd3), 1'b0);
    send_word(datum_word(5'd7, 5'd1, 14'd5), 1'b0);  // stray datum
    send_word(datum_word(5'd7, 5'd1, 14'd5), 1'b0);  // trailer missing after it
  endtask

  task automatic test_data_errors();
    send_word(header_word(5'd5, 8'ha5, 6'd3), 1'b0);
    send_word(datum_word(5'd6, 5'd2, 14'd100), 1'b0);
    send_word(header_word(5'd5, 8'h11, 6'd1), 1'b0);
    send_word(datum_word(5'd5, 5'd9, 14'h2aaa), 1'b0);
    send_word(end_word(5'd5), 1'b0);
  endtask

  task automatic test_missing_trailer();
    send_word(header_word(5'd12, 8'h3c, 6'd1), 1'b0);
    send_word(datum_word(5'd12, 5'd17, 14'h1555), 1'b0);
    send_word(datum_word(5'd12, 5'd18, 14'h0001), 1'b0);
  endtask

  task automatic test_truncation();
    send_word(header_word(5'd9, 8'h42, 6'd4), 1'b1);
    send_word(header_word(5'd10, 8'h81, 6'd2), 1'b0);
    send_word(datum_word(5'd10, 5'd4, 14'h1234), 1'b1);
    send_word(header_word(5'd11, 8'h7e, 6'd1), 1'b0);
    send_word(end_word(5'd11), 1'b1);         // trailer type where data is due
    send_word(datum_word(5'd1, 5'd1, 14'd1), 1'b1);
    send_word(header_word(5'd2, 8'h01, 6'd0), 1'b0);
    send_word(end_word(5'd2), 1'b1);          // last flag on a closing word
  endtask

  task automatic test_random_stream(input int n_items);
    int stop_at;
    stop_at = n_words + n_items;
    while (n_words < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_word($urandom, $urandom_range(0, 7) == 0);
      else play_event();
    end
  endtask

  task automatic test_flat_out();
    flat_out = 1'b1;
    test_random_stream(100);
  endtask

  // Output side stall bursts
  int  stall_run;
  bit  stall_on;
  always @(negedge clk_i) begin
    if (flat_out) begin
      stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on = !stall_on;
        if (stall_on) stall_run = $urandom_range(1, 14);
        else if ($urandom_range(0, 4) == 0) stall_run = $urandom_range(30, 80);
        else stall_run = $urandom_range(1, 20);
      end
      stall_run--;
      stall_i <= stall_on;
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t got_r;
    result_t exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      got_r = {event_end_o, channel_o, value_o, geo_o, crate_o, status_o};
      n_results++;
      if (pending_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected result end %0b chan %0d val %0d geo %0d crate %0d st %0d",
                   $time, got_r.event_end, got_r.channel, got_r.value, got_r.geo,
                   got_r.crate, got_r.status);
      end else begin
        exp_r = pending_results.pop_front();
        status_seen[exp_r.status]++;
        if (exp_r.event_end) n_event_ends++;
        if (got_r.event_end !== exp_r.event_end || got_r.channel !== exp_r.channel ||
            got_r.value !== exp_r.value || got_r.geo !== exp_r.geo ||
            got_r.crate !== exp_r.crate || got_r.status !== exp_r.status) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: mismatch expected end %0b chan %0d val %0d geo %0d crate %0d st %0d",
                     $time, exp_r.event_end, exp_r.channel, exp_r.value, exp_r.geo,
                     exp_r.crate, exp_r.status);
            $display("%0t:          got      end %0b chan %0d val %0d geo %0d crate %0d st %0d",
                     $time, got_r.event_end, got_r.channel, got_r.value, got_r.geo,
                     got_r.crate, got_r.status);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding", IdleLimit,
               pending_results.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    data_word_i = '0;
    last_in_buffer_i = 1'b0;
    stall_i = 1'b0;
    ev_phase = PhHeader;
    words_left = '0;
    ev_geo = '0;
    ev_crate = '0;
    ev_err = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_good_events();
    test_bad_headers();
    test_data_errors();
    test_missing_trailer();
    test_truncation();
    test_random_stream(450);
    test_flat_out();

    valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d words, %0d results, %0d event ends; ok %0d, bad header %0d",
             n_words, n_results, n_event_ends, status_seen[StOk], status_seen[StBadHeader]);
    $display("not data %0d, geo miss %0d, no trailer %0d, truncated %0d; %0d failures",
             status_seen[StNotData], status_seen[StGeoMiss], status_seen[StNoTrailer],
             status_seen[StTruncated], n_fail);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/aewu_pkg.sv
src/aewu_in_stage.sv
src/aewu_decode.sv
src/aewu_out_stage.sv
src/adc_event_word_unpacker.sv
dv/adc_event_word_unpacker_tb.sv
